[rtl/core/jsu_pkg.sv]
// Shared types and codes for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_of_run;
  } out_item_t;

  // Up to three results caused by one input byte.
  typedef struct packed {
    logic [1:0] cnt;
    logic [1:0] status;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } job_t;

endpackage

[rtl/core/jsu_front.sv]
// Parser front end: tracks the string state and turns each byte into a job.
`timescale 1ns / 1ps

module jsu_front
  import jsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t item,
  output logic     push,
  output job_t     job
);

  typedef enum logic [2:0] {
    MODE_WAIT,
    MODE_BODY,
    MODE_ESC,
    MODE_HEX,
    MODE_DONE
  } mode_t;

  mode_t       mode, mode_next;
  logic [1:0]  digits, digits_next;
  logic [15:0] cp, cp_next;

  logic [7:0]  c;
  logic        last;
  logic [4:0]  hv;
  logic [15:0] cp_shift;
  logic        bad, ok;

  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] v;
    v = 5'd16;
    if (ch >= "0" && ch <= "9") v = 5'(ch - 8'h30);
    else if (ch >= "a" && ch <= "f") v = 5'(ch - 8'h57);
    else if (ch >= "A" && ch <= "F") v = 5'(ch - 8'h37);
    return v;
  endfunction

  assign c        = item.data_byte;
  assign last     = item.end_of_input;
  assign hv       = hex_value(c);
  assign cp_shift = {cp[11:0], hv[3:0]};

  always_comb begin
    mode_next   = mode;
    digits_next = digits;
    cp_next     = cp;
    job         = '0;
    job.status  = ST_DATA;
    bad         = 1'b0;
    ok          = 1'b0;
    case (mode)
      MODE_WAIT: begin
        if (c == 8'h22 && !last) mode_next = MODE_BODY;
        else bad = 1'b1;
      end
      MODE_BODY: begin
        if (c == 8'h22) ok = 1'b1;
        else if (last) bad = 1'b1;
        else if (c == 8'h5C) mode_next = MODE_ESC;
        else begin
          job.cnt = 2'd1;
          job.b0  = c;
        end
      end
      MODE_ESC: begin
        if (last) begin
          bad = 1'b1;
        end else begin
          mode_next = MODE_BODY;
          job.cnt   = 2'd1;
          case (c)
            8'h22, 8'h5C, 8'h2F: job.b0 = c;
            8'h6E: job.b0 = 8'h0A;
            8'h72: job.b0 = 8'h0D;
            8'h74: job.b0 = 8'h09;
            8'h62: job.b0 = 8'h08;
            8'h66: job.b0 = 8'h0C;
            8'h75: begin
              job.cnt     = 2'd0;
              mode_next   = MODE_HEX;
              digits_next = 2'd0;
              cp_next     = 16'd0;
            end
            default: bad = 1'b1;
          endcase
        end
      end
      MODE_HEX: begin
        if (hv[4] || last) begin
          bad = 1'b1;
        end else begin
          cp_next = cp_shift;
          if (digits != 2'd3) begin
            digits_next = digits + 2'd1;
          end else begin
            digits_next = 2'd0;
            mode_next   = MODE_BODY;
            if (cp_shift < 16'h0080) begin
              job.cnt = 2'd1;
              job.b0  = cp_shift[7:0];
            end else if (cp_shift < 16'h0800) begin
              job.cnt = 2'd2;
              job.b0  = 8'hC0 | {3'd0, cp_shift[10:6]};
              job.b1  = 8'h80 | {2'd0, cp_shift[5:0]};
            end else begin
              job.cnt = 2'd3;
              job.b0  = 8'hE0 | {4'd0, cp_shift[15:12]};
              job.b1  = 8'h80 | {2'd0, cp_shift[11:6]};
              job.b2  = 8'h80 | {2'd0, cp_shift[5:0]};
            end
          end
        end
      end
      default: ;
    endcase

    if (bad || ok) begin
      job        = '0;
      job.cnt    = 2'd1;
      job.status = bad ? ST_BAD : ST_OK;
      mode_next  = MODE_DONE;
    end
    if (last) begin
      mode_next   = MODE_WAIT;
      digits_next = 2'd0;
      cp_next     = 16'd0;
    end
  end

  assign push = accept && (job.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_WAIT;
      digits <= 2'd0;
      cp     <= 16'd0;
    end else if (accept) begin
      mode   <= mode_next;
      digits <= digits_next;
      cp     <= cp_next;
    end
  end

endmodule

[rtl/core/jsu_queue.sv]
// Short job queue between the parser and the result sequencer.
`timescale 1ns / 1ps

module jsu_queue
  import jsu_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t rd_job,
  output logic full,
  output logic empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem [Depth];
  logic [PtrW-1:0] wptr, rptr;
  logic [CntW-1:0] count;

  assign full   = (count == CntW'(Depth));
  assign empty  = (count == '0);
  assign rd_job = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + 1'b1;
      if (pop) rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("Job pushed into a full queue.");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("Job popped from an empty queue.");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("Queue count out of range.");

endmodule

[rtl/core/jsu_back.sv]
// Result sequencer: holds one job and hands out its results one per cycle while ready is high.
`timescale 1ns / 1ps

module jsu_back
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  input  job_t      q_job,
  output logic      pop,
  output logic      valid,
  input  logic      ready,
  output out_item_t item
);

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       fin, load;

  assign valid = cur_valid;

  always_comb begin
    case (idx)
      2'd0:    item.out_byte = cur.b0;
      2'd1:    item.out_byte = cur.b1;
      default: item.out_byte = cur.b2;
    endcase
    item.status      = cur.status;
    item.last_of_run = (idx == cur.cnt - 2'd1);
  end

  assign fin  = cur_valid && ready && item.last_of_run;
  assign load = !cur_valid || fin;
  assign pop  = load && !q_empty;

  always_ff @(posedge clk) begin
    if (load) cur <= q_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      cur_valid <= !q_empty;
      idx       <= 2'd0;
    end else if (ready) begin
      idx <= idx + 2'd1;
    end
  end

  a_status_ends: assert property (@(posedge clk) disable iff (rst)
    (valid && item.status != ST_DATA) |-> item.last_of_run)
    else $error("Status item is not the last of its run.");
  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> cur.cnt != 2'd0)
    else $error("Empty job reached the output.");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> idx < cur.cnt)
    else $error("Result index past the end of the job.");

endmodule

[rtl/core/json_string_unescaper.sv]
// Top level of the JSON string unescaper: parser, job queue and result sequencer.
// Each job is written to the queue, then loaded into the sequencer, before it is offered.
// Throughput: one byte per cycle while each byte yields at most one result and the
// output is ready; the two or three UTF-8 bytes of a \uXXXX escape go out one by one.
// The two-entry job queue lets the parser keep taking bytes while the output stalls.
// Reset returns the parser to waiting for an opening quote and empties the queue.
`timescale 1ns / 1ps

module json_string_unescaper
  import jsu_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  in_item_t  byte_item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result_item
);

  logic q_full, q_empty, push, pop;
  job_t new_job, head_job;

  assign byte_ready = !q_full;

  jsu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (byte_valid && byte_ready),
    .item   (byte_item),
    .push   (push),
    .job    (new_job)
  );

  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (new_job),
    .pop    (pop),
    .rd_job (head_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  jsu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_job   (head_job),
    .pop     (pop),
    .valid   (result_valid),
    .ready   (result_ready),
    .item    (result_item)
  );

endmodule
